// ===== design/assert_macros.svh =====
// Assertion macros used by the thruster mixer design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define TM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/thrmix_pkg.sv =====
// Types and constants of the thruster mixer.
`timescale 1ns / 1ps

package thrmix_pkg;

    localparam int MAX_MOTORS  = 8;
    localparam int AXES        = 6;
    localparam int MOTOR_W     = $clog2(MAX_MOTORS);
    localparam int AXIS_W      = $clog2(AXES);
    localparam int COEF_DEPTH  = MAX_MOTORS * AXES;
    localparam int ADDR_W      = $clog2(COEF_DEPTH);
    localparam int DATA_W      = 16;
    localparam int MAG_W       = 15;
    localparam int CNT_W       = 4;
    localparam int SEL_W       = 4;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int SCALE_SHIFT = 14;
    localparam int SCALED_W    = ACC_W - SCALE_SHIFT;
    localparam int REV_W       = SCALED_W + 1;
    localparam int SHAPE_W     = REV_W + 1;

    // Input tdata layout
    localparam int IDX_LSB     = 0;
    localparam int SEL_LSB     = IDX_LSB + MOTOR_W;
    localparam int VAL_LSB     = SEL_LSB + SEL_W;
    localparam int CMD_LSB     = VAL_LSB + DATA_W;
    localparam int IN_USED_W   = CMD_LSB + AXES * DATA_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout
    localparam int THR_LSB     = MOTOR_W;
    localparam int OUT_USED_W  = THR_LSB + DATA_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]  MOTOR_COUNT_RST = CNT_W'(6);
    localparam logic [AXIS_W-1:0] AXIS_LAST       = AXIS_W'(AXES - 1);

    localparam logic REQ_MIX  = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [SEL_W-1:0] WS_REVERSED = SEL_W'(6);
    localparam logic [SEL_W-1:0] WS_DZ_POS   = SEL_W'(7);
    localparam logic [SEL_W-1:0] WS_DZ_NEG   = SEL_W'(8);
    localparam logic [SEL_W-1:0] WS_LIM_POS  = SEL_W'(9);
    localparam logic [SEL_W-1:0] WS_LIM_NEG  = SEL_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_SHAPE
    } t_state;

endpackage

// ===== design/thruster_mixer.sv =====
// Thruster mixer top level: coefficient table, shared multiply-accumulate and output shaping.
// A mix item returns one drive value per active motor (motor_count, clamped to 1..8), in motor
// order, the last one marked by tlast. For each motor the six axis coefficients are fed through
// the single 16x16 multiplier, the read, multiply and accumulate stages drain, and the sum is
// scaled and then shaped; s_axis_tready is low for the whole mix. The shape step waits while
// the output register still holds an unaccepted drive value, so a stalled m_axis_tready
// lengthens the mix. A load item writes one table word in the cycle it is accepted
// (word_select 11..15 writes nothing) and gives no result. motor_count is written through
// i_cfg_we/i_cfg_wdata and must only change while no mix is in progress.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thruster_mixer
    import thrmix_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CNT_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // motor_index, word_select, word_value, roll_cmd, pitch_cmd, yaw_cmd, vertical_cmd,
    // forward_cmd, lateral_cmd, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // motor_number, thrust, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]         r_motor_count;
    logic [DATA_W-1:0]        r_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]    r_cvalid;
    logic                     r_rev [MAX_MOTORS];
    logic [MAG_W-1:0]         r_dzp [MAX_MOTORS];
    logic [MAG_W-1:0]         r_dzn [MAX_MOTORS];
    logic [MAG_W-1:0]         r_lmp [MAX_MOTORS];
    logic [MAG_W-1:0]         r_lmn [MAX_MOTORS];

    logic signed [DATA_W-1:0] r_cmd [AXES];
    logic [ADDR_W-1:0]        r_addr;
    logic [AXIS_W-1:0]        r_axis;
    logic [AXIS_W-1:0]        r_rd_axis;
    logic [MOTOR_W-1:0]       r_motor;
    logic [MOTOR_W-1:0]       r_last;
    logic [DATA_W-1:0]        r_mem_q;
    logic                     r_rd_ok;
    logic                     r_rd_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_zero;
    logic signed [REV_W-1:0]  r_v;

    logic                     r_out_vld;
    logic [MOTOR_W-1:0]       r_out_motor;
    logic [DATA_W-1:0]        r_out_thrust;
    logic                     r_out_last;

    logic                     in_acc;
    logic                     load_en;
    logic                     start;
    logic                     issue;
    logic                     scale_en;
    logic                     out_load;

    logic [MOTOR_W-1:0]       ld_idx;
    logic [SEL_W-1:0]         ld_sel;
    logic signed [DATA_W-1:0] ld_val;
    logic [MAG_W-1:0]         ld_mag;
    logic [ADDR_W-1:0]        ld_addr;
    logic [MOTOR_W-1:0]       start_last;

    logic signed [DATA_W-1:0]   coef;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [REV_W-1:0]    scaled_x;
    logic signed [SHAPE_W-1:0]  v_dz;
    logic signed [SHAPE_W-1:0]  lim_lo;
    logic signed [SHAPE_W-1:0]  lim_hi;
    logic signed [SHAPE_W-1:0]  v_clamp;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign load_en       = in_acc && (s_axis_tuser == REQ_LOAD);

    assign ld_idx  = s_axis_tdata[IDX_LSB +: MOTOR_W];
    assign ld_sel  = s_axis_tdata[SEL_LSB +: SEL_W];
    assign ld_val  = s_axis_tdata[VAL_LSB +: DATA_W];
    assign ld_mag  = ld_val[DATA_W-1] ? '0 : ld_val[MAG_W-1:0];
    assign ld_addr = ADDR_W'(ld_idx) * ADDR_W'(AXES) + ADDR_W'(ld_sel);

    always_comb begin
        if (r_motor_count == '0) begin
            start_last = '0;
        end else if (r_motor_count > CNT_W'(MAX_MOTORS)) begin
            start_last = MOTOR_W'(MAX_MOTORS - 1);
        end else begin
            start_last = MOTOR_W'(r_motor_count - CNT_W'(1));
        end
    end

    always_comb begin
        n_state  = r_state;
        start    = 1'b0;
        issue    = 1'b0;
        scale_en = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (s_axis_tuser == REQ_MIX)) begin
                    start   = 1'b1;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                issue = 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                scale_en = 1'b1;
                n_state  = ST_SHAPE;
            end
            ST_SHAPE: begin
                if (!r_out_vld || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = (r_motor == r_last) ? ST_IDLE : ST_MAC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= MOTOR_COUNT_RST;
        end else if (i_cfg_we) begin
            r_motor_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en && (ld_sel < SEL_W'(AXES))) begin
            r_mem[ld_addr] <= ld_val;
        end
        if (issue) begin
            r_mem_q <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            for (int m = 0; m < MAX_MOTORS; m++) begin
                r_rev[m] <= 1'b0;
                r_dzp[m] <= '0;
                r_dzn[m] <= '0;
                r_lmp[m] <= '0;
                r_lmn[m] <= '0;
            end
        end else if (load_en) begin
            if (ld_sel < SEL_W'(AXES)) begin
                r_cvalid[ld_addr] <= 1'b1;
            end
            if (ld_sel == WS_REVERSED) begin
                r_rev[ld_idx] <= ld_val[0];
            end
            if (ld_sel == WS_DZ_POS) begin
                r_dzp[ld_idx] <= ld_mag;
            end
            if (ld_sel == WS_DZ_NEG) begin
                r_dzn[ld_idx] <= ld_mag;
            end
            if (ld_sel == WS_LIM_POS) begin
                r_lmp[ld_idx] <= ld_mag;
            end
            if (ld_sel == WS_LIM_NEG) begin
                r_lmn[ld_idx] <= ld_mag;
            end
        end
    end

    assign coef = r_rd_ok ? r_mem_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_axis     <= '0;
            r_rd_axis  <= '0;
            r_motor    <= '0;
            r_last     <= '0;
            r_rd_ok    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_rd_vld   <= issue;
            r_prod_vld <= r_rd_vld;
            if (start) begin
                r_addr  <= '0;
                r_axis  <= '0;
                r_motor <= '0;
                r_last  <= start_last;
                r_acc   <= '0;
            end else begin
                if (issue) begin
                    r_addr    <= r_addr + ADDR_W'(1);
                    r_axis    <= (r_axis == AXIS_LAST) ? '0 : r_axis + AXIS_W'(1);
                    r_rd_axis <= r_axis;
                    r_rd_ok   <= r_cvalid[r_addr];
                end
                if (out_load) begin
                    r_motor <= r_motor + MOTOR_W'(1);
                    r_acc   <= '0;
                end else if (r_prod_vld) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            for (int a = 0; a < AXES; a++) begin
                r_cmd[a] <= s_axis_tdata[CMD_LSB + a * DATA_W +: DATA_W];
            end
        end
        if (r_rd_vld) begin
            r_prod <= coef * r_cmd[r_rd_axis];
        end
    end

    assign scaled   = r_acc[ACC_W-1:SCALE_SHIFT];
    assign scaled_x = REV_W'(scaled);

    always_ff @(posedge i_clk) begin
        if (scale_en) begin
            r_zero <= (r_acc == '0);
            r_v    <= r_rev[r_motor] ? -scaled_x : scaled_x;
        end
    end

    assign lim_lo = -SHAPE_W'({1'b0, r_lmn[r_motor]});
    assign lim_hi = SHAPE_W'({1'b0, r_lmp[r_motor]});

    always_comb begin
        if (r_v < 0) begin
            v_dz = SHAPE_W'(r_v) - SHAPE_W'({1'b0, r_dzn[r_motor]});
        end else begin
            v_dz = SHAPE_W'(r_v) + SHAPE_W'({1'b0, r_dzp[r_motor]});
        end
        priority if (r_zero) begin
            v_clamp = '0;
        end else if (v_dz > lim_hi) begin
            v_clamp = lim_hi;
        end else if (v_dz < lim_lo) begin
            v_clamp = lim_lo;
        end else begin
            v_clamp = v_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_motor  <= r_motor;
            r_out_thrust <= v_clamp[DATA_W-1:0];
            r_out_last   <= (r_motor == r_last);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_thrust, r_out_motor});

    `TM_ASSERT(a_motor_in_range, i_clk, i_rst_n,
               (r_state == ST_IDLE) || (r_motor <= r_last),
               "motor counter passed last active motor")
    `TM_ASSERT(a_pipe_empty, i_clk, i_rst_n,
               (r_state != ST_SCALE) || (!r_rd_vld && !r_prod_vld),
               "scaling before accumulation finished")
    `TM_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, out_load, m_axis_tvalid,
                    "shaped result not presented")
    `TM_ASSERT_NEXT(a_mix_start, i_clk, i_rst_n, start,
                    (r_state == ST_MAC) && (r_acc == '0) && (r_motor == '0),
                    "mix did not start clean")

endmodule

// ===== tb/thruster_mixer_tb.sv =====
// Self-checking testbench for the thruster mixer: table loads, mixes and stream pacing.
`timescale 1ns / 1ps

module thruster_mixer_tb;
    import thrmix_pkg::*;

    localparam logic [SEL_W-1:0] WS_ROLL        = SEL_W'(0);
    localparam logic [SEL_W-1:0] WS_PITCH       = SEL_W'(1);
    localparam logic [SEL_W-1:0] WS_YAW         = SEL_W'(2);
    localparam logic [SEL_W-1:0] WS_VERTICAL    = SEL_W'(3);
    localparam logic [SEL_W-1:0] WS_FORWARD     = SEL_W'(4);
    localparam logic [SEL_W-1:0] WS_LATERAL     = SEL_W'(5);
    localparam logic [SEL_W-1:0] WS_SPARE_FIRST = SEL_W'(11);
    localparam logic [SEL_W-1:0] WS_SPARE_LAST  = SEL_W'(15);

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [DATA_W-1:0]  thrust;
        logic               last;
    } t_drive;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // mirror of the motor tables and the active motor count
    logic signed [DATA_W-1:0] coef_tbl   [MAX_MOTORS][AXES];
    logic                     rev_tbl    [MAX_MOTORS];
    logic [MAG_W-1:0]         dz_pos_tbl [MAX_MOTORS];
    logic [MAG_W-1:0]         dz_neg_tbl [MAX_MOTORS];
    logic [MAG_W-1:0]         lim_pos_tbl[MAX_MOTORS];
    logic [MAG_W-1:0]         lim_neg_tbl[MAX_MOTORS];
    logic [CNT_W-1:0]         motor_count_cfg = MOTOR_COUNT_RST;

    t_drive drive_q[$];
    t_drive drive_want;
    int     idle_pct   = 0;
    int     stall_pct  = 0;
    int     fail_count = 0;
    int     n_loads    = 0;
    int     n_mixes    = 0;
    int     n_drives   = 0;

    thruster_mixer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                $error("motor_number: expected none, got %0d (thrust %0d)",
                       m_axis_tdata[MOTOR_W-1:0], $signed(m_axis_tdata[THR_LSB +: DATA_W]));
                fail_count++;
            end else begin
                drive_want = drive_q.pop_front();
                n_drives++;
                if (m_axis_tdata[MOTOR_W-1:0] !== drive_want.motor) begin
                    $error("motor_number: expected %0d, got %0d",
                           drive_want.motor, m_axis_tdata[MOTOR_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[THR_LSB +: DATA_W] !== drive_want.thrust) begin
                    $error("thrust: expected %0d, got %0d", $signed(drive_want.thrust),
                           $signed(m_axis_tdata[THR_LSB +: DATA_W]));
                    fail_count++;
                end
                if (m_axis_tlast !== drive_want.last) begin
                    $error("last_motor: expected %0d, got %0d", drive_want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [MAG_W-1:0] clip_magnitude(logic signed [DATA_W-1:0] val);
        return (val < 0) ? '0 : val[MAG_W-1:0];
    endfunction

    task automatic clear_tables();
        for (int m = 0; m < MAX_MOTORS; m++) begin
            for (int a = 0; a < AXES; a++) coef_tbl[m][a] = '0;
            rev_tbl[m]     = 1'b0;
            dz_pos_tbl[m]  = '0;
            dz_neg_tbl[m]  = '0;
            lim_pos_tbl[m] = '0;
            lim_neg_tbl[m] = '0;
        end
    endtask

    // Apply a load to the table mirror, or queue the drive values a mix produces.
    task automatic predict_drives(input logic req, input logic [IN_TDATA_W-1:0] td);
        logic [MOTOR_W-1:0]       idx;
        logic [SEL_W-1:0]         sel;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] cmd [AXES];
        int                       count;
        longint                   acc;
        longint                   v;
        longint                   lo;
        longint                   hi;
        t_drive                   d;
        if (req == REQ_LOAD) begin
            idx = td[IDX_LSB +: MOTOR_W];
            sel = td[SEL_LSB +: SEL_W];
            val = td[VAL_LSB +: DATA_W];
            n_loads++;
            if (sel < AXES) begin
                coef_tbl[idx][sel] = val;
            end else begin
                case (sel)
                    WS_REVERSED: rev_tbl[idx]     = val[0];
                    WS_DZ_POS:   dz_pos_tbl[idx]  = clip_magnitude(val);
                    WS_DZ_NEG:   dz_neg_tbl[idx]  = clip_magnitude(val);
                    WS_LIM_POS:  lim_pos_tbl[idx] = clip_magnitude(val);
                    WS_LIM_NEG:  lim_neg_tbl[idx] = clip_magnitude(val);
                    default: ;
                endcase
            end
        end else begin
            n_mixes++;
            count = (motor_count_cfg == 0) ? 1 :
                    (motor_count_cfg > MAX_MOTORS) ? MAX_MOTORS : int'(motor_count_cfg);
            for (int a = 0; a < AXES; a++) cmd[a] = td[CMD_LSB + a * DATA_W +: DATA_W];
            for (int m = 0; m < count; m++) begin
                acc = 0;
                for (int a = 0; a < AXES; a++)
                    acc += longint'(coef_tbl[m][a]) * longint'(cmd[a]);
                if (acc == 0) begin
                    v = 0;
                end else begin
                    v = acc >>> SCALE_SHIFT;
                    if (rev_tbl[m]) v = -v;
                    if (v < 0) v = v - longint'(dz_neg_tbl[m]);
                    else       v = v + longint'(dz_pos_tbl[m]);
                    lo = -longint'(lim_neg_tbl[m]);
                    hi = longint'(lim_pos_tbl[m]);
                    if (v < lo) v = lo;
                    if (v > hi) v = hi;
                end
                d.motor  = MOTOR_W'(m);
                d.thrust = v[DATA_W-1:0];
                d.last   = (m == count - 1);
                drive_q.push_back(d);
            end
        end
    endtask

    task automatic send_item(input logic req, input logic [IN_TDATA_W-1:0] td);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= td;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_drives(req, td);
    endtask

    task automatic load_word(input int idx, input logic [SEL_W-1:0] sel,
                             input logic [DATA_W-1:0] val);
        logic [IN_TDATA_W-1:0] td;
        td = '0;
        td[IDX_LSB +: MOTOR_W] = MOTOR_W'(idx);
        td[SEL_LSB +: SEL_W]   = sel;
        td[VAL_LSB +: DATA_W]  = val;
        send_item(REQ_LOAD, td);
    endtask

    // commands packed roll first: {lateral, forward, vertical, yaw, pitch, roll}
    task automatic mix_commands(input logic [AXES*DATA_W-1:0] cmds);
        logic [IN_TDATA_W-1:0] td;
        td = '0;
        td[CMD_LSB +: AXES*DATA_W] = cmds;
        send_item(REQ_MIX, td);
    endtask

    task automatic wait_quiet(input int tail);
        s_axis_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic set_motor_count(input logic [CNT_W-1:0] count);
        wait_quiet(4);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        motor_count_cfg = count;
    endtask

    function automatic logic [DATA_W-1:0] rand_command();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DATA_W'($urandom_range(0, 128) - 64);
            default: return DATA_W'($urandom());
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_word(logic [SEL_W-1:0] sel);
        if (sel < AXES)
            return $urandom_range(0, 1) ? DATA_W'($urandom()) :
                                          DATA_W'($urandom_range(0, 8192) - 4096);
        case (sel)
            WS_DZ_POS, WS_DZ_NEG:
                return ($urandom_range(0, 3) == 0) ? DATA_W'($urandom()) :
                                                     DATA_W'($urandom_range(0, 400));
            WS_LIM_POS, WS_LIM_NEG:
                return ($urandom_range(0, 3) == 0) ? DATA_W'($urandom()) :
                                                     DATA_W'($urandom_range(2000, 32767));
            default:
                return DATA_W'($urandom());
        endcase
    endfunction

    // Unused fields of each item carry random noise.
    task automatic random_items(input int count);
        logic [IN_TDATA_W-1:0] td;
        logic [SEL_W-1:0]      sel;
        for (int i = 0; i < count; i++) begin
            td = IN_TDATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
            td[IN_TDATA_W-1:IN_USED_W] = '0;
            if ($urandom_range(0, 99) < 35) begin
                sel = SEL_W'($urandom_range(0, 15));
                td[IDX_LSB +: MOTOR_W] = MOTOR_W'($urandom_range(0, MAX_MOTORS - 1));
                td[SEL_LSB +: SEL_W]   = sel;
                td[VAL_LSB +: DATA_W]  = rand_word(sel);
                send_item(REQ_LOAD, td);
            end else begin
                for (int a = 0; a < AXES; a++)
                    td[CMD_LSB + a * DATA_W +: DATA_W] = rand_command();
                send_item(REQ_MIX, td);
            end
        end
    endtask

    task automatic test_reset_state();
        mix_commands({6{16'h4000}});
        mix_commands({16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000});
    endtask

    task automatic test_table_extremes();
        set_motor_count(CNT_W'(8));
        load_word(0, WS_ROLL, 16'h7FFF);
        load_word(0, WS_PITCH, 16'h8000);
        load_word(0, WS_LIM_POS, 16'h7FFF);
        load_word(0, WS_LIM_NEG, 16'h7FFF);
        load_word(1, WS_ROLL, 16'h0001);
        load_word(1, WS_LIM_NEG, 16'h7FFF);
        load_word(2, WS_YAW, 16'h4000);
        load_word(2, WS_REVERSED, 16'hFFFE);
        load_word(2, WS_REVERSED, 16'h0001);
        load_word(2, WS_LIM_POS, 16'h7FFF);
        load_word(2, WS_LIM_NEG, 16'h7FFF);
        load_word(3, WS_VERTICAL, 16'h4000);
        load_word(3, WS_DZ_POS, 16'hFFFB);
        load_word(3, WS_DZ_NEG, 16'd100);
        load_word(3, WS_LIM_POS, 16'h7FFF);
        load_word(3, WS_LIM_NEG, 16'd50);
        load_word(4, WS_SPARE_FIRST, 16'h7FFF);
        load_word(4, WS_SPARE_LAST, 16'h7FFF);
        load_word(7, WS_FORWARD, 16'h7FFF);
        load_word(7, WS_LATERAL, 16'hC000);
        load_word(7, WS_LIM_POS, 16'd1000);
        mix_commands({6{16'h8000}});
        mix_commands({6{16'h7FFF}});
        mix_commands({80'h0, 16'hFFFF});
        mix_commands('0);
    endtask

    // cancelling coefficients: an exactly zero sum bypasses the deadzone
    task automatic test_zero_sum();
        load_word(5, WS_ROLL, 16'd100);
        load_word(5, WS_PITCH, -16'sd100);
        load_word(5, WS_DZ_POS, 16'd300);
        load_word(5, WS_LIM_POS, 16'h7FFF);
        mix_commands({64'h0, 16'd5, 16'd5});
        mix_commands({64'h0, 16'd0, 16'd5});
    endtask

    task automatic test_limit_setup();
        for (int m = 0; m < MAX_MOTORS; m++) begin
            load_word(m, WS_LIM_POS, DATA_W'($urandom_range(4000, 32767)));
            load_word(m, WS_LIM_NEG, DATA_W'($urandom_range(4000, 32767)));
        end
    endtask

    task automatic test_pacing(input int idle, input int stall,
                               input logic [CNT_W-1:0] count_a,
                               input logic [CNT_W-1:0] count_b, input int items);
        idle_pct  = idle;
        stall_pct = stall;
        set_motor_count(count_a);
        random_items(items / 2);
        set_motor_count(count_b);
        random_items(items - items / 2);
    endtask

    initial begin
        #20_000_000;
        $display("thruster_mixer verification failed");
        $finish;
    end

    initial begin
        clear_tables();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_table_extremes();
        test_zero_sum();
        test_limit_setup();
        test_pacing(0, 0, CNT_W'(8), CNT_W'(3), 80);
        test_pacing(54, 0, CNT_W'(1), CNT_W'(0), 80);
        test_pacing(0, 54, CNT_W'(15), CNT_W'(6), 80);
        test_pacing(15, 15, CNT_W'(7), CNT_W'(8), 80);
        wait_quiet(100);
        $display("Covered %0d table loads and %0d mixes; %0d drive values checked",
                 n_loads, n_mixes, n_drives);
        $display("Motor counts 0, 1, 3, 6, 7, 8 and 15 under four pacing phases");
        if (fail_count == 0) begin
            $display("thruster_mixer verification clean");
        end else begin
            $display("thruster_mixer verification failed");
        end
        $finish;
    end

endmodule
